// File: design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants for the trial division prime tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int DEF_TABLE_DEPTH = 8192;
  localparam int DEF_VALUE_BITS  = 32;

  localparam int PRIME_W    = 16;
  localparam int RESULT_W   = 32;
  localparam int DIGIT_BITS = 4;

  localparam logic [PRIME_W-1:0] STORE_LIMIT_RESET = 16'hFFFF;
  localparam int                 MIN_PRIME         = 2;

endpackage

// File: design/trial_division_prime_tester.sv
// ----------------------------------------------------------------------------
// trial_division_prime_tester
// Tests candidates by trial division against a table of primes found so far.
// Feed candidates in increasing order from 2. Pulse start with in_candidate
// while busy is low; the item is taken at that edge and busy stays high until
// the result is out. The result is on the out_ ports for one cycle, marked by
// out_valid; the receiver cannot stall it. The next item may start in that
// cycle, so the item period equals the latency.
// Per item the FSM runs S_SQ and S_RANGE; out of range or below 2 it goes
// straight to S_DONE. Else each stored prime in turn is read through the
// single table read port (S_FETCH); S_TEST goes to S_STORE once its square
// exceeds the candidate, else S_DIV takes S = ceil(VALUE_BITS / 4) digits at
// 4 bits a cycle. A dividing prime ends in S_DONE; a spent table, like an
// empty one, leads to S_STORE, which ends in S_DONE.
// cfg_data sets store_limit; cfg_ready is high while idle with start low.
// Reset clears the prime count and sets store_limit to 65535; the table
// itself is not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module trial_division_prime_tester #(
  parameter int TABLE_DEPTH = tdpt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = tdpt_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [VALUE_BITS-1:0]         in_candidate,
  output logic                          out_valid,
  output logic [tdpt_pkg::RESULT_W-1:0] out_tested_value,
  output logic                          out_is_prime,
  output logic                          out_out_of_range,
  output logic                          out_was_stored,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tdpt_pkg::PRIME_W-1:0]  cfg_data
);

  localparam int PW     = tdpt_pkg::PRIME_W;
  localparam int RW     = tdpt_pkg::RESULT_W;
  localparam int DIGIT  = tdpt_pkg::DIGIT_BITS;
  localparam int STEPS  = (VALUE_BITS + DIGIT - 1) / DIGIT;
  localparam int PAD_W  = STEPS * DIGIT;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (VALUE_BITS > 2 * PW + 1) ? VALUE_BITS : 2 * PW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] x_r, x_nxt;
  logic [PW-1:0]         limit_r, limit_nxt;
  logic [2*PW+1:0]       bound_sq_r, bound_sq_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [PW-1:0]         last_r, last_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic [2*PW-1:0]       p_sq_r, p_sq_nxt;
  logic [PW-1:0]         rem_r, rem_nxt;
  logic [PAD_W-1:0]      xs_r, xs_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  prime_r, prime_nxt;
  logic                  range_r, range_nxt;
  logic                  stored_r, stored_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [PW-1:0]         table_mem [TABLE_DEPTH];
  logic [PW-1:0]         rd_data_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;

  logic [PW:0]           div_try;
  logic [PW-1:0]         div_rem;
  logic [PAD_W-1:0]      div_xs;
  logic [CNT_W-1:0]      idx_inc;
  logic                  store_ok;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign idx_inc   = idx_r + CNT_W'(1);

  // one remainder digit: DIGIT restoring steps
  always_comb begin
    div_rem = rem_r;
    div_xs  = xs_r;
    div_try = '0;
    for (int k = 0; k < DIGIT; k++) begin
      div_try = {div_rem, div_xs[PAD_W-1]};
      div_xs  = div_xs << 1;
      if (div_try >= {1'b0, p_r}) begin
        div_try = div_try - {1'b0, p_r};
      end
      div_rem = div_try[PW-1:0];
    end
  end

  assign store_ok = prime_r &&
                    (CMP_W'(x_r) <= CMP_W'(limit_r)) &&
                    (count_r < CNT_W'(TABLE_DEPTH)) &&
                    ((count_r == '0) || (CMP_W'(x_r) > CMP_W'(last_r)));

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    limit_nxt     = limit_r;
    bound_sq_nxt  = bound_sq_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    p_sq_nxt      = p_sq_r;
    rem_nxt       = rem_r;
    xs_nxt        = xs_r;
    step_nxt      = step_r;
    prime_nxt     = prime_r;
    range_nxt     = range_r;
    stored_nxt    = stored_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt      = in_candidate;
          prime_nxt  = 1'b0;
          range_nxt  = 1'b0;
          stored_nxt = 1'b0;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        bound_sq_nxt = (2*PW+2)'({1'b0, limit_r} + 17'd1) * (2*PW+2)'({1'b0, limit_r} + 17'd1);
        state_nxt    = S_RANGE;
      end
      S_RANGE: begin
        idx_nxt = '0;
        if (CMP_W'(x_r) >= CMP_W'(bound_sq_r)) begin
          range_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (x_r < VALUE_BITS'(tdpt_pkg::MIN_PRIME)) begin
          state_nxt = S_DONE;
        end else begin
          prime_nxt = 1'b1;
          if (count_r == '0) begin
            state_nxt = S_STORE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        p_nxt     = rd_data_r;
        p_sq_nxt  = (2*PW)'(rd_data_r) * (2*PW)'(rd_data_r);
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (CMP_W'(p_sq_r) > CMP_W'(x_r)) begin
          state_nxt = S_STORE;
        end else if (p_r == '0) begin
          idx_nxt = idx_inc;
          if (idx_inc == count_r) begin
            state_nxt = S_STORE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_inc[IDX_W-1:0];
            state_nxt = S_FETCH;
          end
        end else begin
          rem_nxt   = '0;
          xs_nxt    = PAD_W'(x_r);
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = div_rem;
        xs_nxt   = div_xs;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          if (div_rem == '0) begin
            prime_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_inc;
            if (idx_inc == count_r) begin
              state_nxt = S_STORE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = idx_inc[IDX_W-1:0];
              state_nxt = S_FETCH;
            end
          end
        end
      end
      S_STORE: begin
        if (store_ok) begin
          wr_en      = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          last_nxt   = PW'(x_r);
          stored_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= tdpt_pkg::STORE_LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    bound_sq_r <= bound_sq_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    p_r        <= p_nxt;
    p_sq_r     <= p_sq_nxt;
    rem_r      <= rem_nxt;
    xs_r       <= xs_nxt;
    step_r     <= step_nxt;
    prime_r    <= prime_nxt;
    range_r    <= range_nxt;
    stored_r   <= stored_nxt;
  end

  // prime table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[count_r[IDX_W-1:0]] <= PW'(x_r);
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tested_value = RW'(x_r);
  assign out_is_prime     = prime_r;
  assign out_out_of_range = range_r;
  assign out_was_stored   = stored_r;

endmodule
